FILE: src/bisc_pkg.sv
// Shared types, constants and elaboration helpers of the image scaler core.
package bisc_pkg;

  localparam int DEF_MAX_SOURCE_WIDTH  = 1024;
  localparam int DEF_MAX_SOURCE_HEIGHT = 1024;
  localparam int DEF_MAX_CHANNELS      = 3;
  localparam int QUEUE_DEPTH           = 4;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 27;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SOURCE_WIDTH       = 3'd0,
    CFG_SOURCE_HEIGHT      = 3'd1,
    CFG_HORIZONTAL_RATIO   = 3'd2,
    CFG_VERTICAL_RATIO     = 3'd3,
    CFG_CHANNEL_COUNT      = 3'd4,
    CFG_INTERPOLATION_MODE = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [10:0] source_width;
    logic [10:0] source_height;
    logic [26:0] horizontal_ratio;
    logic [26:0] vertical_ratio;
    logic [1:0]  channel_count;
    logic        interpolation_mode;
  } bisc_cfg_t;

  typedef struct packed {
    logic        action;
    logic [9:0]  source_column;
    logic [9:0]  source_row;
    logic [1:0]  channel_index;
    logic [7:0]  source_byte;
    logic [13:0] output_column;
    logic [13:0] output_row;
  } bisc_item_t;

  typedef struct packed {
    logic        sample;
    logic        wr_en;
    logic [7:0]  wr_data;
    logic [1:0]  wr_bank;
    logic        nearest;
    logic [1:0]  b00;
    logic [1:0]  b10;
    logic [1:0]  b01;
    logic [1:0]  b11;
    logic [15:0] fx;
    logic [15:0] fy;
    logic [13:0] column;
    logic [13:0] row;
    logic [1:0]  channel;
  } bisc_cmd_t;

  typedef struct packed {
    logic [7:0]  sample_value;
    logic [13:0] sample_column;
    logic [13:0] sample_row;
    logic [1:0]  sample_channel;
  } bisc_result_t;

  function automatic int idx_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic int bank_depth(input int mw, input int mh, input int mc);
    return ((mw + 1) / 2) * ((mh + 1) / 2) * mc;
  endfunction

endpackage

FILE: src/bisc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bisc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW   = bisc_pkg::idx_width(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/bisc_queue.sv
// Short flip-flop queue between the front and back sections.
module bisc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bisc_pkg::QUEUE_DEPTH,
  localparam int PW   = bisc_pkg::idx_width(DEPTH),
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CNTW-1:0]  count_r;

  assign full  = (count_r == CNTW'(DEPTH));
  assign valid = (count_r != '0);
  assign dout  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: src/bisc_front.sv
// Front section: accepts items, maps sample positions and forms bank commands.
module bisc_front #(
  parameter int MAX_SOURCE_WIDTH  = bisc_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = bisc_pkg::DEF_MAX_SOURCE_HEIGHT,
  parameter int MAX_CHANNELS      = bisc_pkg::DEF_MAX_CHANNELS,
  localparam int AW = bisc_pkg::idx_width(
    bisc_pkg::bank_depth(MAX_SOURCE_WIDTH, MAX_SOURCE_HEIGHT, MAX_CHANNELS))
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bisc_pkg::bisc_cfg_t  cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bisc_pkg::bisc_item_t in_item,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [3:0][AW-1:0]   q_addr,
  output bisc_pkg::bisc_cmd_t  q_cmd
);

  localparam int CW         = bisc_pkg::idx_width(MAX_SOURCE_WIDTH);
  localparam int RW         = bisc_pkg::idx_width(MAX_SOURCE_HEIGHT);
  localparam int CHW        = bisc_pkg::idx_width(MAX_CHANNELS);
  localparam int BANK_COLS  = (MAX_SOURCE_WIDTH + 1) / 2;
  localparam int ROW_STRIDE = BANK_COLS * MAX_CHANNELS;
  localparam int PXW        = 14 + 27;

  logic adv;

  logic            s1_v_r;
  logic            s1_act_r;
  logic [9:0]      s1_scol_r;
  logic [9:0]      s1_srow_r;
  logic [1:0]      s1_ch_r;
  logic [CHW-1:0]  s1_c_r;
  logic [7:0]      s1_byte_r;
  logic [13:0]     s1_ocol_r;
  logic [13:0]     s1_orow_r;
  logic [PXW-1:0]  s1_px_r;
  logic [PXW-1:0]  s1_py_r;
  logic            s1_wok_r;

  logic [31:0]     ncm1;
  logic [CHW-1:0]  c_nxt;
  logic            wok_nxt;

  logic            s2_v_r;
  bisc_pkg::bisc_cmd_t cmd_r;
  bisc_pkg::bisc_cmd_t cmd_nxt;
  logic [CW-1:0]   x0_r, x1_r, x0_nxt, x1_nxt;
  logic [RW-1:0]   y0_r, y1_r, y0_nxt, y1_nxt;
  logic [CHW-1:0]  c_r;

  logic [31:0]     wm1, hm1, ix, iy, x0w, y0w;

  assign adv      = !s2_v_r || !q_full;
  assign in_ready = adv;
  assign q_push   = s2_v_r && !q_full;
  assign q_cmd    = cmd_r;

  always_comb begin
    if (cfg.channel_count == 2'd0) begin
      ncm1 = 32'd0;
    end else if (32'(cfg.channel_count) > 32'(MAX_CHANNELS)) begin
      ncm1 = 32'(MAX_CHANNELS - 1);
    end else begin
      ncm1 = 32'(cfg.channel_count) - 32'd1;
    end
    if (!in_item.action || 32'(in_item.channel_index) <= ncm1) begin
      c_nxt = CHW'(32'(in_item.channel_index));
    end else begin
      c_nxt = CHW'(ncm1);
    end
    wok_nxt = (32'(in_item.source_column) < 32'(MAX_SOURCE_WIDTH)) &&
              (32'(in_item.source_row) < 32'(MAX_SOURCE_HEIGHT)) &&
              (32'(in_item.channel_index) < 32'(MAX_CHANNELS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_act_r  <= in_item.action;
      s1_scol_r <= in_item.source_column;
      s1_srow_r <= in_item.source_row;
      s1_ch_r   <= in_item.channel_index;
      s1_c_r    <= c_nxt;
      s1_byte_r <= in_item.source_byte;
      s1_ocol_r <= in_item.output_column;
      s1_orow_r <= in_item.output_row;
      s1_px_r   <= PXW'(in_item.output_column) * PXW'(cfg.horizontal_ratio);
      s1_py_r   <= PXW'(in_item.output_row) * PXW'(cfg.vertical_ratio);
      s1_wok_r  <= wok_nxt;
    end
  end

  always_comb begin
    if (cfg.source_width == 11'd0) begin
      wm1 = 32'd0;
    end else if (32'(cfg.source_width) > 32'(MAX_SOURCE_WIDTH)) begin
      wm1 = 32'(MAX_SOURCE_WIDTH - 1);
    end else begin
      wm1 = 32'(cfg.source_width) - 32'd1;
    end
    if (cfg.source_height == 11'd0) begin
      hm1 = 32'd0;
    end else if (32'(cfg.source_height) > 32'(MAX_SOURCE_HEIGHT)) begin
      hm1 = 32'(MAX_SOURCE_HEIGHT - 1);
    end else begin
      hm1 = 32'(cfg.source_height) - 32'd1;
    end
    ix = 32'(s1_px_r[PXW-1:16]);
    iy = 32'(s1_py_r[PXW-1:16]);
    if (!s1_act_r) begin
      x0w = 32'(s1_scol_r);
      y0w = 32'(s1_srow_r);
    end else begin
      x0w = (ix >= wm1) ? wm1 : ix;
      y0w = (iy >= hm1) ? hm1 : iy;
    end
    x0_nxt = x0w[CW-1:0];
    y0_nxt = y0w[RW-1:0];
    x1_nxt = (x0w == wm1) ? x0_nxt : x0_nxt + 1'b1;
    y1_nxt = (y0w == hm1) ? y0_nxt : y0_nxt + 1'b1;

    cmd_nxt.sample  = s1_act_r;
    cmd_nxt.wr_en   = !s1_act_r && s1_wok_r;
    cmd_nxt.wr_data = s1_byte_r;
    cmd_nxt.wr_bank = {y0_nxt[0], x0_nxt[0]};
    cmd_nxt.nearest = cfg.interpolation_mode;
    cmd_nxt.b00     = {y0_nxt[0], x0_nxt[0]};
    cmd_nxt.b10     = {y0_nxt[0], x1_nxt[0]};
    cmd_nxt.b01     = {y1_nxt[0], x0_nxt[0]};
    cmd_nxt.b11     = {y1_nxt[0], x1_nxt[0]};
    cmd_nxt.fx      = s1_px_r[15:0];
    cmd_nxt.fy      = s1_py_r[15:0];
    cmd_nxt.column  = s1_ocol_r;
    cmd_nxt.row     = s1_orow_r;
    cmd_nxt.channel = s1_ch_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_r <= cmd_nxt;
      x0_r  <= x0_nxt;
      x1_r  <= x1_nxt;
      y0_r  <= y0_nxt;
      y1_r  <= y1_nxt;
      c_r   <= s1_c_r;
    end
  end

  always_comb begin
    logic [CW-1:0] xs;
    logic [RW-1:0] ys;
    logic [31:0]   addr;
    for (int b = 0; b < 4; b++) begin
      xs = (x0_r[0] == b[0]) ? x0_r : x1_r;
      ys = (y0_r[0] == b[1]) ? y0_r : y1_r;
      addr = 32'(ys >> 1) * 32'(ROW_STRIDE) + 32'(xs >> 1) * 32'(MAX_CHANNELS) + 32'(c_r);
      q_addr[b] = addr[AW-1:0];
    end
  end

endmodule

FILE: src/bisc_back.sv
// Back section: frame banks, neighbour selection, blend and result register.
module bisc_back #(
  parameter int MAX_SOURCE_WIDTH  = bisc_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = bisc_pkg::DEF_MAX_SOURCE_HEIGHT,
  parameter int MAX_CHANNELS      = bisc_pkg::DEF_MAX_CHANNELS,
  localparam int BD = bisc_pkg::bank_depth(MAX_SOURCE_WIDTH, MAX_SOURCE_HEIGHT, MAX_CHANNELS),
  localparam int AW = bisc_pkg::idx_width(BD)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  logic [3:0][AW-1:0]     q_addr,
  input  bisc_pkg::bisc_cmd_t    q_cmd,
  output logic                   out_valid,
  input  logic                   out_ready,
  output bisc_pkg::bisc_result_t out_res
);

  logic       adv;
  logic [7:0] rd [4];

  logic                b_v_r;
  bisc_pkg::bisc_cmd_t cmd_b_r;
  logic [7:0]          v00, v10, v01, v11;
  logic signed [8:0]   dx_top, dx_bot;
  logic signed [25:0]  top_s, bot_s;

  logic                c_v_r;
  bisc_pkg::bisc_cmd_t cmd_c_r;
  logic [23:0]         top_c_r, bot_c_r;
  logic [7:0]          v00_c_r;
  logic signed [24:0]  dy;
  logic signed [41:0]  acc;
  logic [41:0]         rsum;
  logic [9:0]          vq;
  logic [7:0]          value;

  logic                   out_valid_r;
  bisc_pkg::bisc_result_t out_res_r;

  assign adv   = !out_valid_r || out_ready;
  assign q_pop = q_valid && adv;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    bisc_ram #(
      .WIDTH(8),
      .DEPTH(BD)
    ) u_bank (
      .clk  (clk),
      .we   (q_pop && q_cmd.wr_en && (q_cmd.wr_bank == 2'(b))),
      .waddr(q_addr[b]),
      .wdata(q_cmd.wr_data),
      .re   (adv),
      .raddr(q_addr[b]),
      .rdata(rd[b])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      b_v_r       <= q_pop && q_cmd.sample;
      c_v_r       <= b_v_r;
      out_valid_r <= c_v_r;
    end
  end

  always_comb begin
    v00    = rd[cmd_b_r.b00];
    v10    = rd[cmd_b_r.b10];
    v01    = rd[cmd_b_r.b01];
    v11    = rd[cmd_b_r.b11];
    dx_top = $signed({1'b0, v10}) - $signed({1'b0, v00});
    dx_bot = $signed({1'b0, v11}) - $signed({1'b0, v01});
    top_s  = $signed({2'b00, v00, 16'h0000}) + dx_top * $signed({1'b0, cmd_b_r.fx});
    bot_s  = $signed({2'b00, v01, 16'h0000}) + dx_bot * $signed({1'b0, cmd_b_r.fx});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_b_r <= q_cmd;
      cmd_c_r <= cmd_b_r;
      top_c_r <= top_s[23:0];
      bot_c_r <= bot_s[23:0];
      v00_c_r <= v00;
    end
  end

  always_comb begin
    dy   = $signed({1'b0, bot_c_r}) - $signed({1'b0, top_c_r});
    acc  = $signed({2'b00, top_c_r, 16'h0000}) + dy * $signed({1'b0, cmd_c_r.fy});
    rsum = $unsigned(acc) + (42'd1 << 31);
    vq   = rsum[41:32];
    if (cmd_c_r.nearest) begin
      value = v00_c_r;
    end else if (vq > 10'd255) begin
      value = 8'hFF;
    end else begin
      value = vq[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r.sample_value   <= value;
      out_res_r.sample_column  <= cmd_c_r.column;
      out_res_r.sample_row     <= cmd_c_r.row;
      out_res_r.sample_channel <= cmd_c_r.channel;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

FILE: src/bilinear_nearest_image_scaler_core.sv
// Top level of the bilinear and nearest neighbour image scaler core.
//
// Channel  Role    One transaction
// in_*     slave   a source byte write or a sample request (tuser = action)
// out_*    master  one resampled byte for each sample request
// cfg_*    write   one register write, no read-back
//
// One item is accepted every cycle unless a full queue holds up the front section; the four
// parity-split frame banks each give one read and take one write per cycle.
// A sample request passes the front registers s1 and s2, the queue, the bank read, blend and result registers.
// Reset is synchronous; the frame store is not cleared and needs no sweep.
// A four-entry queue absorbs output stalls; in_tready falls once it is full and the front holds a command.
module bilinear_nearest_image_scaler_core #(
  parameter int MAX_SOURCE_WIDTH  = bisc_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = bisc_pkg::DEF_MAX_SOURCE_HEIGHT,
  parameter int MAX_CHANNELS      = bisc_pkg::DEF_MAX_CHANNELS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // source_column, source_row, channel_index, source_byte, output_column, output_row
  input  logic [bisc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // sample_value, sample_column, sample_row, sample_channel
  output logic [bisc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_we,
  input  logic [bisc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bisc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = bisc_pkg::idx_width(
    bisc_pkg::bank_depth(MAX_SOURCE_WIDTH, MAX_SOURCE_HEIGHT, MAX_CHANNELS));
  localparam int QW = 4 * AW + $bits(bisc_pkg::bisc_cmd_t);

  bisc_pkg::bisc_cfg_t    cfg_r;
  bisc_pkg::bisc_item_t   item;
  bisc_pkg::bisc_cmd_t    f_cmd, b_cmd;
  bisc_pkg::bisc_result_t res;
  logic [3:0][AW-1:0]     f_addr, b_addr;
  logic                   q_full, q_push, q_pop, q_valid;
  logic [QW-1:0]          q_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_width       <= 11'd1;
      cfg_r.source_height      <= 11'd1;
      cfg_r.horizontal_ratio   <= 27'd65536;
      cfg_r.vertical_ratio     <= 27'd65536;
      cfg_r.channel_count      <= 2'd1;
      cfg_r.interpolation_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (bisc_pkg::cfg_index_t'(cfg_index))
        bisc_pkg::CFG_SOURCE_WIDTH:       cfg_r.source_width       <= cfg_wdata[10:0];
        bisc_pkg::CFG_SOURCE_HEIGHT:      cfg_r.source_height      <= cfg_wdata[10:0];
        bisc_pkg::CFG_HORIZONTAL_RATIO:   cfg_r.horizontal_ratio   <= cfg_wdata;
        bisc_pkg::CFG_VERTICAL_RATIO:     cfg_r.vertical_ratio     <= cfg_wdata;
        bisc_pkg::CFG_CHANNEL_COUNT:      cfg_r.channel_count      <= cfg_wdata[1:0];
        bisc_pkg::CFG_INTERPOLATION_MODE: cfg_r.interpolation_mode <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    item.action        = in_tuser;
    item.source_column = in_tdata[9:0];
    item.source_row    = in_tdata[19:10];
    item.channel_index = in_tdata[21:20];
    item.source_byte   = in_tdata[29:22];
    item.output_column = in_tdata[43:30];
    item.output_row    = in_tdata[57:44];
  end

  bisc_front #(
    .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT(MAX_SOURCE_HEIGHT),
    .MAX_CHANNELS     (MAX_CHANNELS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_item (item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_addr  (f_addr),
    .q_cmd   (f_cmd)
  );

  bisc_queue #(
    .WIDTH(QW),
    .DEPTH(bisc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .din  ({f_addr, f_cmd}),
    .full (q_full),
    .pop  (q_pop),
    .valid(q_valid),
    .dout (q_dout)
  );

  assign {b_addr, b_cmd} = q_dout;

  bisc_back #(
    .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT(MAX_SOURCE_HEIGHT),
    .MAX_CHANNELS     (MAX_CHANNELS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_addr   (b_addr),
    .q_cmd    (b_cmd),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res)
  );

  assign out_tdata = {2'b00, res.sample_channel, res.sample_row,
                      res.sample_column, res.sample_value};

endmodule
